### rtl/core/pure_pursuit_steering_assert.svh
// Assertion macros for the steering block.
`ifndef PURE_PURSUIT_STEERING_ASSERT_SVH
`define PURE_PURSUIT_STEERING_ASSERT_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;
  localparam int COORD_BITS_DEF   = 10;
  localparam int CORDIC_STEPS_DEF = 16;
  // shared multiplier operand width
  localparam int MW = 29;

  // status codes
  localparam logic [2:0] STAT_OK   = 3'd0;
  localparam logic [2:0] STAT_FEW  = 3'd1;
  localparam logic [2:0] STAT_NONE = 3'd2;
  localparam logic [2:0] STAT_NEAR = 3'd3;
  localparam logic [2:0] STAT_TINY = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_WHEELBASE = 3'd0;
  localparam logic [2:0] CFG_MAX_LA    = 3'd1;
  localparam logic [2:0] CFG_PPM       = 3'd2;
  localparam logic [2:0] CFG_AXLE_OFF  = 3'd3;
  localparam logic [2:0] CFG_MAX_STEER = 3'd4;
  localparam logic [2:0] CFG_IMG_W     = 3'd5;
  localparam logic [2:0] CFG_IMG_H     = 3'd6;

  // atan(2^-i) in 1/65536 centidegree
  function automatic logic [29:0] atan_tab(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd294912000;
      5'd1:  v = 30'd174096719;
      5'd2:  v = 30'd91987925;
      5'd3:  v = 30'd46694507;
      5'd4:  v = 30'd23437865;
      5'd5:  v = 30'd11730358;
      5'd6:  v = 30'd5866610;
      5'd7:  v = 30'd2933484;
      5'd8:  v = 30'd1466765;
      5'd9:  v = 30'd733385;
      5'd10: v = 30'd366693;
      5'd11: v = 30'd183346;
      5'd12: v = 30'd91673;
      5'd13: v = 30'd45837;
      5'd14: v = 30'd22918;
      5'd15: v = 30'd11459;
      5'd16: v = 30'd5730;
      5'd17: v = 30'd2865;
      5'd18: v = 30'd1432;
      5'd19: v = 30'd716;
      5'd20: v = 30'd358;
      5'd21: v = 30'd179;
      5'd22: v = 30'd90;
      5'd23: v = 30'd45;
      default: v = 30'd0;
    endcase
    return v;
  endfunction
endpackage

### rtl/core/pure_pursuit_steering.sv
`timescale 1ns / 1ps
// Pure-pursuit steering over a streamed path.
// Input channel (in_valid/in_ready): one path point per transfer, with the
// vehicle speed; in_last_point closes the path. Output channel
// (out_valid/out_ready): one result per closed path, the clamped steering
// angle in centidegrees and a status code (steering is zero unless ok).
// Config channel (cfg_valid/cfg_ready, index/data) is always ready; write
// it only while the block is idle.
// A point on or behind the axle passes the sequencer steps Q13 to LAR and
// then END before the next possible transfer; a point ahead adds DY2, SUM,
// the distance square root (17 root bits) and UPD. in_ready is low meanwhile.
// A last point then goes through the 4 setup steps, the CORDIC loop, rounding
// and the output load when the status is ok, and the output load alone
// otherwise; out_valid rises in the cycle in which in_ready returns.
// The result sits in an output register; if the receiver stalls, non-last
// points proceed normally and a later last point waits in its output step
// until the earlier result is taken.
// Reset restores the register defaults and clears the path state.
module pure_pursuit_steering #(
  parameter int COORD_BITS   = pps_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic signed [12:0]    in_speed_mm_s,
  input  logic                  in_last_point,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [14:0]    out_steering_centideg,
  output logic [2:0]            out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [13:0]           cfg_data
);
  import pps_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DXW  = ((CB + 1 > 11) ? CB + 1 : 11) + 1;
  localparam int DYW  = ((CB + 2 > 14) ? CB + 2 : 14) + 1;
  localparam int FW   = 13;
  localparam int SW   = ((2 * (DXW - 1) > 2 * FW) ? 2 * (DXW - 1) : 2 * FW) + 1;
  localparam int SQW  = ((SW + 7) / 2) * 2;
  localparam int DW   = SQW / 2;
  localparam int CW   = ((24 + DXW > SW + 10) ? 24 + DXW : SW + 10) + 3;
  localparam int CIW  = $clog2(CORDIC_STEPS);
  localparam int EW   = 21;
  localparam int PW   = 2 * MW;

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_Q13  = 5'd1;
  localparam logic [4:0] S_DIV  = 5'd2;
  localparam logic [4:0] S_LD   = 5'd3;
  localparam logic [4:0] S_LDP  = 5'd4;
  localparam logic [4:0] S_LA   = 5'd5;
  localparam logic [4:0] S_LAR  = 5'd6;
  localparam logic [4:0] S_DY2  = 5'd7;
  localparam logic [4:0] S_SUM  = 5'd8;
  localparam logic [4:0] S_SQRT = 5'd9;
  localparam logic [4:0] S_UPD  = 5'd10;
  localparam logic [4:0] S_END  = 5'd11;
  localparam logic [4:0] S_F1   = 5'd12;
  localparam logic [4:0] S_F2   = 5'd13;
  localparam logic [4:0] S_F3   = 5'd14;
  localparam logic [4:0] S_F4   = 5'd15;
  localparam logic [4:0] S_CORD = 5'd16;
  localparam logic [4:0] S_RND  = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  // configuration registers
  logic [9:0]         wb_r;
  logic [11:0]        maxla_r;
  logic [11:0]        ppm_r;
  logic signed [10:0] off_r;
  logic [13:0]        maxst_r;
  logic [10:0]        imgw_r;
  logic [10:0]        imgh_r;

  logic [4:0]  state_r, state_nxt;
  logic [1:0]  cnt_r;
  logic        have_r;
  logic        last_r;
  logic [11:0] spd_r;
  logic signed [DXW-1:0] dx_r;
  logic signed [DYW-1:0] dy_r;
  logic [11:0] ld_r;
  logic [18:0] la_r;
  logic [SW-1:0] sq_r;
  logic [SW-1:0] s_r;
  logic [SW-1:0] s_sum;
  logic signed [PW-1:0] prod_r;
  logic signed [MW-1:0] mul_a, mul_b;

  logic [16:0]           best_err_r;
  logic [FW-1:0]         best_fwd_r;
  logic [DW-1:0]         best_dist_r;
  logic signed [DXW-1:0] best_dx_r;
  logic [SW-1:0]         best_s_r;

  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [31:0]   z_r;
  logic [CIW-1:0]       ci_r;
  logic [2:0]           stat_r;
  logic signed [14:0]   res_r;

  logic               ov_r;
  logic signed [14:0] osteer_r;
  logic [2:0]         ostat_r;

  logic          sq_start, sq_done;
  logic [DW-1:0] sq_root;

  // squared distance, scaled by 64 for the Q.4 root
  assign s_sum = sq_r + prod_r[SW-1:0];

  pps_isqrt #(.W(SQW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (SQW'({s_sum, 6'b0})),
    .done     (sq_done),
    .root     (sq_root)
  );

  logic in_fire;
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign sq_start  = (state_r == S_SUM);

  // accept-time geometry
  logic signed [DXW-1:0] dx_in;
  logic signed [DYW-1:0] dyh, dy_in;
  always_comb begin
    dx_in = DXW'($signed({1'b0, in_point_x, 1'b0})) - DXW'($signed({1'b0, imgw_r}));
    dyh   = DYW'($signed({1'b0, imgh_r})) - DYW'(off_r);
    dy_in = (dyh <<< 1) - DYW'($signed({1'b0, in_point_y, 1'b0}));
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_Q13: begin
        mul_a = MW'($signed({1'b0, spd_r}));
        mul_b = MW'(13);
      end
      S_DIV: begin
        mul_a = MW'($signed({1'b0, prod_r[15:0]}));
        mul_b = MW'(52429);
      end
      S_LDP: begin
        mul_a = MW'($signed({1'b0, ld_r}));
        mul_b = MW'($signed({1'b0, ppm_r}));
      end
      S_LA: begin
        mul_a = MW'($signed({1'b0, prod_r[23:0], 1'b0}));
        mul_b = MW'(68719477);
      end
      S_LAR: begin
        mul_a = MW'(dx_r);
        mul_b = MW'(dx_r);
      end
      S_DY2: begin
        mul_a = MW'($signed({1'b0, dy_r[FW-1:0]}));
        mul_b = MW'($signed({1'b0, dy_r[FW-1:0]}));
      end
      S_F1: begin
        mul_a = MW'($signed({1'b0, wb_r}));
        mul_b = MW'($signed({1'b0, ppm_r}));
      end
      S_F2: begin
        mul_a = MW'($signed({1'b0, prod_r[21:0]}));
        mul_b = MW'(best_dx_r);
      end
      S_F3: begin
        mul_a = MW'($signed({1'b0, best_s_r}));
        mul_b = MW'(1000);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // lookahead clamp
  logic [12:0] ld_sum;
  logic [11:0] la_max;
  always_comb begin
    ld_sum = 13'd250 + {1'b0, prod_r[31:20]};
    la_max = (maxla_r < 12'd250) ? 12'd250 : maxla_r;
  end

  // error against lookahead, and the keep decision
  logic signed [EW-1:0] e_s;
  logic [EW-1:0]        e_abs;
  logic [16:0]          err;
  logic                 keep;
  always_comb begin
    e_s   = EW'($signed({1'b0, sq_root})) - EW'($signed({1'b0, la_r}));
    e_abs = e_s[EW-1] ? EW'(-e_s) : EW'(e_s);
    err   = (e_abs > EW'(131071)) ? 17'd131071 : e_abs[16:0];
    keep  = !have_r || (err < best_err_r) ||
            ((err == best_err_r) && (dy_r[FW-1:0] > best_fwd_r));
  end

  // end-of-path checks
  logic [2:0]  stat_c;
  logic [DW+4:0] d25;
  always_comb begin
    d25 = (DW+5)'({best_dist_r, 4'b0}) + (DW+5)'({best_dist_r, 3'b0}) +
          (DW+5)'(best_dist_r);
    if (cnt_r < 2'd2) begin
      stat_c = STAT_FEW;
    end else if (ppm_r == '0 || imgw_r == '0 || imgh_r == '0) begin
      stat_c = STAT_NONE;
    end else if (!have_r) begin
      stat_c = STAT_NONE;
    end else if ({1'b0, best_dist_r, 1'b0} < (DW+2)'(la_r)) begin
      stat_c = STAT_NEAR;
    end else if (d25 < (DW+5)'({ppm_r, 2'b0})) begin
      stat_c = STAT_TINY;
    end else begin
      stat_c = STAT_OK;
    end
  end

  // CORDIC step and final rounding
  logic signed [CW-1:0] xs, ys;
  logic signed [31:0]   at;
  logic signed [31:0]   zp, zn;
  logic signed [16:0]   zr;
  logic signed [16:0]   lim;
  always_comb begin
    xs  = cx_r >>> ci_r;
    ys  = cy_r >>> ci_r;
    at  = 32'($signed({1'b0, atan_tab(5'(ci_r))}));
    zp  = (z_r + 32'sd32768) >>> 16;
    zn  = -((-z_r + 32'sd32768) >>> 16);
    zr  = (z_r >= 0) ? zp[16:0] : zn[16:0];
    lim = 17'($signed({1'b0, maxst_r}));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_Q13;
      S_Q13:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_LD;
      S_LD:   state_nxt = S_LDP;
      S_LDP:  state_nxt = S_LA;
      S_LA:   state_nxt = S_LAR;
      S_LAR:  state_nxt = (dy_r > 0) ? S_DY2 : S_END;
      S_DY2:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_SQRT;
      S_SQRT: if (sq_done) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_END;
      S_END: begin
        if (!last_r) state_nxt = S_IDLE;
        else if (stat_c == STAT_OK) state_nxt = S_F1;
        else state_nxt = S_OUT;
      end
      S_F1:   state_nxt = S_F2;
      S_F2:   state_nxt = S_F3;
      S_F3:   state_nxt = S_F4;
      S_F4:   state_nxt = S_CORD;
      S_CORD: if (ci_r == CIW'(CORDIC_STEPS - 1)) state_nxt = S_RND;
      S_RND:  state_nxt = S_OUT;
      S_OUT:  if (!ov_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
      have_r  <= 1'b0;
      ov_r    <= 1'b0;
      wb_r    <= 10'd252;
      maxla_r <= 12'd350;
      ppm_r   <= 12'd250;
      off_r   <= 11'sd40;
      maxst_r <= 14'd2500;
      imgw_r  <= 11'd640;
      imgh_r  <= 11'd480;
    end else begin
      state_r <= state_nxt;
      // config writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WHEELBASE: wb_r    <= cfg_data[9:0];
          CFG_MAX_LA:    maxla_r <= cfg_data[11:0];
          CFG_PPM:       ppm_r   <= cfg_data[11:0];
          CFG_AXLE_OFF:  off_r   <= $signed(cfg_data[10:0]);
          CFG_MAX_STEER: maxst_r <= cfg_data;
          CFG_IMG_W:     imgw_r  <= cfg_data[10:0];
          CFG_IMG_H:     imgh_r  <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_fire && cnt_r < 2'd2) cnt_r <= cnt_r + 2'd1;
      if (state_r == S_UPD && keep) have_r <= 1'b1;
      // output register
      if (state_r == S_OUT && (!ov_r || out_ready)) begin
        ov_r   <= 1'b1;
        cnt_r  <= 2'd0;
        have_r <= 1'b0;
      end else if (out_valid && out_ready) begin
        ov_r <= 1'b0;
      end
    end

    prod_r <= mul_a * mul_b;
    if (in_fire) begin
      spd_r  <= in_speed_mm_s[12] ? 12'd0 : in_speed_mm_s[11:0];
      last_r <= in_last_point;
      dx_r   <= dx_in;
      dy_r   <= dy_in;
    end
    if (state_r == S_LD) ld_r <= (ld_sum > {1'b0, la_max}) ? la_max : ld_sum[11:0];
    if (state_r == S_LAR) la_r <= prod_r[51:33];
    if (state_r == S_DY2) sq_r <= prod_r[SW-1:0];
    if (state_r == S_SUM) s_r <= s_sum;
    if (state_r == S_UPD && keep) begin
      best_err_r  <= err;
      best_fwd_r  <= dy_r[FW-1:0];
      best_dist_r <= sq_root;
      best_dx_r   <= dx_r;
      best_s_r    <= s_r;
    end
    if (state_r == S_END) begin
      stat_r <= stat_c;
      res_r  <= '0;
    end
    if (state_r == S_F3) cy_r <= {prod_r[CW-3:0], 2'b00};
    if (state_r == S_F4) begin
      cx_r <= prod_r[CW-1:0];
      z_r  <= '0;
      ci_r <= '0;
    end
    // one CORDIC rotation per cycle
    if (state_r == S_CORD) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        z_r  <= z_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        z_r  <= z_r - at;
      end
      ci_r <= ci_r + 1'b1;
    end
    if (state_r == S_RND) begin
      if (zr > lim) res_r <= lim[14:0];
      else if (zr < -lim) res_r <= 15'(-lim);
      else res_r <= zr[14:0];
    end
    if (state_r == S_OUT && (!ov_r || out_ready)) begin
      osteer_r <= res_r;
      ostat_r  <= stat_r;
    end
  end

  assign out_valid             = ov_r;
  assign out_steering_centideg = osteer_r;
  assign out_status            = ostat_r;

`include "pure_pursuit_steering_assert.svh"
  `PPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
  `PPS_ASSERT_SAME(a_zero_on_fail, clk, rst_n, out_valid && out_status != STAT_OK, out_steering_centideg == 15'sd0)
  `PPS_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, out_status <= STAT_TINY)
endmodule

### rtl/core/pps_isqrt.sv
`timescale 1ns / 1ps
module pps_isqrt #(
  parameter int W = 34
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic           done,
  output logic [W/2-1:0] root
);
  import pps_pkg::*;

  localparam int KW = (W/2 > 1) ? $clog2(W/2) : 1;
  localparam logic [KW-1:0] KTOP = KW'(W/2 - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [W-1:0]  v_r, v_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  bitv;
  logic [W:0]    trial;

  // one result bit per cycle, digit-by-digit square root
  always_comb begin
    bitv     = W'(1) << {k_r, 1'b0};
    trial    = {1'b0, r_r} + {1'b0, bitv};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    v_nxt    = v_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = KTOP;
      v_nxt    = radicand;
      r_nxt    = '0;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= trial) begin
        v_nxt = v_r - trial[W-1:0];
        r_nxt = (r_r >> 1) + bitv;
      end else begin
        r_nxt = r_r >> 1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r <= k_nxt;
    v_r <= v_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign root = r_r[W/2-1:0];
endmodule

### test/pure_pursuit_steering_tb.sv
`timescale 1ns / 1ps
module pure_pursuit_steering_tb;
  import pps_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] in_point_x = '0;
  logic [9:0] in_point_y = '0;
  logic signed [12:0] in_speed_mm_s = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [14:0] out_steering_centideg;
  logic [2:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;

  typedef struct packed {
    logic signed [14:0] steer;
    logic [2:0] status;
  } steer_result_t;

  steer_result_t steer_q[$];
  int err_count = 0;
  int stall_mode = 0;

  // predictor copy of registers
  longint wheelbase, max_la, ppm, axle_off, max_steer, img_w, img_h;
  // predictor copy of path state
  int pts;
  bit tgt;
  longint b_err, b_fwd, b_dist, b_dx;

  always #5 clk = ~clk;

  pure_pursuit_steering u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_speed_mm_s(in_speed_mm_s), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_steering_centideg(out_steering_centideg), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_tab(i[4:0]));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_tab(i[4:0]));
      end
    end
    return z;
  endfunction

  task automatic clear_path();
    pts = 0; tgt = 0; b_err = 0; b_fwd = 0; b_dist = 0; b_dx = 0;
  endtask

  task automatic restore_defaults();
    wheelbase = 252; max_la = 350; ppm = 250; axle_off = 40;
    max_steer = 2500; img_w = 640; img_h = 480;
    clear_path();
  endtask

  // track one accepted point; queue a result on a last point
  task automatic predict_point(logic [9:0] x, logic [9:0] y, logic signed [12:0] spd_in,
                               logic last);
    longint spd, ld, lmax, la, dx2, dy2, pdist, e, f, s, yy, xx, z, st;
    steer_result_t r;
    spd = spd_in;
    if (spd < 0) spd = 0;
    ld = 250 + (13 * spd) / 20;
    lmax = (max_la < 250) ? 250 : max_la;
    if (ld > lmax) ld = lmax;
    la = (ld * ppm * 16) / 1000;
    if (pts < 2) pts++;
    dx2 = 2 * longint'(x) - img_w;
    dy2 = 2 * (img_h - axle_off) - 2 * longint'(y);
    if (dy2 > 0) begin
      pdist = root_floor((dx2 * dx2 + dy2 * dy2) * 64);
      e = pdist - la;
      if (e < 0) e = -e;
      if (e > 131071) e = 131071;
      if (!tgt || e < b_err || (e == b_err && dy2 > b_fwd)) begin
        tgt = 1; b_err = e; b_fwd = dy2; b_dist = pdist; b_dx = dx2;
      end
    end
    if (!last) return;
    st = 0;
    if (pts < 2) r.status = STAT_FEW;
    else if (ppm == 0 || img_w == 0 || img_h == 0) r.status = STAT_NONE;
    else if (!tgt) r.status = STAT_NONE;
    else if (2 * b_dist < la) r.status = STAT_NEAR;
    else if (b_dist * 100 < ppm * 16) r.status = STAT_TINY;
    else begin
      r.status = STAT_OK;
      f = b_fwd;
      s = b_dx * b_dx + f * f;
      yy = 4 * wheelbase * ppm * b_dx;
      xx = 1000 * s;
      z = atan_angle(yy, xx);
      if (z >= 0) st = (z + 32768) >>> 16;
      else st = -((-z + 32768) >>> 16);
      if (st > max_steer) st = max_steer;
      if (st < -max_steer) st = -max_steer;
    end
    r.steer = st[14:0];
    steer_q.push_back(r);
    clear_path();
  endtask

  // one point transfer, then a random gap sometimes
  task automatic send_point(logic [9:0] x, logic [9:0] y, logic signed [12:0] spd,
                            logic last);
    in_valid <= 1'b1;
    in_point_x <= x; in_point_y <= y; in_speed_mm_s <= spd; in_last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(x, y, spd, last);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (steer_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val[13:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WHEELBASE: wheelbase = val & 'h3FF;
      CFG_MAX_LA:    max_la = val & 'hFFF;
      CFG_PPM:       ppm = val & 'hFFF;
      CFG_AXLE_OFF:  axle_off = (val & 'h400) ? (val & 'h7FF) - 2048 : (val & 'h7FF);
      CFG_MAX_STEER: max_steer = val & 'h3FFF;
      CFG_IMG_W:     img_w = val & 'h7FF;
      CFG_IMG_H:     img_h = val & 'h7FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(longint wb, longint la, longint p, longint ax, longint ms,
                           longint w, longint h);
    write_reg(CFG_WHEELBASE, wb);
    write_reg(CFG_MAX_LA, la);
    write_reg(CFG_PPM, p);
    write_reg(CFG_AXLE_OFF, ax & 'h7FF);
    write_reg(CFG_MAX_STEER, ms);
    write_reg(CFG_IMG_W, w);
    write_reg(CFG_IMG_H, h);
  endtask

  function automatic logic signed [12:0] rand_speed();
    case ($urandom_range(0, 4))
      0: return -13'sd4096;
      1: return 13'sd4095;
      2: return 13'($urandom_range(0, 600));
      default: return 13'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_point(10'd320, 10'd300, 13'sd0, 1'b1);          // single point: too few
    send_point(10'd320, 10'd470, 13'sd0, 1'b0);          // both behind axle
    send_point(10'd0, 10'd1023, -13'sd4096, 1'b1);
    send_point(10'd320, 10'd200, 13'sd0, 1'b0);          // straight ahead
    send_point(10'd320, 10'd100, 13'sd0, 1'b1);
    send_point(10'd1023, 10'd0, 13'sd4095, 1'b0);        // hard right, far
    send_point(10'd1023, 10'd100, 13'sd4095, 1'b1);
    send_point(10'd0, 10'd0, 13'sd1000, 1'b0);           // hard left
    send_point(10'd0, 10'd200, 13'sd1000, 1'b1);
    send_point(10'd321, 10'd439, 13'sd0, 1'b0);          // target very near
    send_point(10'd320, 10'd439, 13'sd0, 1'b1);
    send_point(10'd300, 10'd350, 13'sd100, 1'b0);        // equal error, earlier kept
    send_point(10'd340, 10'd350, 13'sd100, 1'b0);
    send_point(10'd340, 10'd350, 13'sd100, 1'b1);
    send_point(10'd500, 10'd380, 13'sd0, 1'b0);
    send_point(10'd140, 10'd380, 13'sd0, 1'b1);
    wait_idle();
  endtask

  task automatic test_tiny_distance();
    // large scale puts near points under 0.01 m and under half lookahead
    write_all(1000, 11, 4095, 0, 9000, 2, 2);
    send_point(10'd1, 10'd0, 13'sd0, 1'b0);
    send_point(10'd1, 10'd0, 13'sd0, 1'b1);
    wait_idle();
    write_all(11, 4000, 1, -1024, 1, 1, 1);
    send_point(10'd0, 10'd0, 13'sd4095, 1'b0);
    send_point(10'd1023, 10'd1023, 13'sd4095, 1'b1);
    send_point(10'd512, 10'd512, 13'sd0, 1'b0);
    send_point(10'd0, 10'd1023, 13'sd0, 1'b1);
    wait_idle();
  endtask

  task automatic test_zero_config();
    write_all(0, 0, 0, 1023, 0, 0, 0);
    send_point(10'd5, 10'd5, 13'sd0, 1'b0);
    send_point(10'd5, 10'd5, 13'sd0, 1'b1);
    wait_idle();
    write_reg(CFG_PPM, 250);
    write_reg(CFG_IMG_W, 0);
    send_point(10'd5, 10'd5, 13'sd0, 1'b0);
    send_point(10'd5, 10'd5, 13'sd0, 1'b1);
    wait_idle();
    write_all(0, 350, 250, 40, 2500, 640, 480);          // zero wheelbase: angle zero
    send_point(10'd500, 10'd200, 13'sd0, 1'b0);
    send_point(10'd500, 10'd200, 13'sd0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_paths(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      for (int k = 0; k < len; k++) begin
        send_point(10'($urandom_range(0, 1023)),
                   ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                     10'($urandom_range(0, (img_h > 40) ? int'(img_h) - 20 : 1023)),
                   rand_speed(), k == len - 1);
        sent++;
      end
    end
    wait_idle();
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 6; p++) begin
      write_all($urandom_range(11, 1000), $urandom_range(11, 4000),
                $urandom_range(50, 4095), int'($urandom_range(0, 2047)) - 1024,
                $urandom_range(1, 9000), $urandom_range(1, 1024),
                $urandom_range(1, 1024));
      stall_mode = p % 3;
      test_random_paths(180);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    case (stall_mode)
      0: out_ready <= ($urandom_range(0, 2) != 0);
      1: out_ready <= 1'b1;
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    steer_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (steer_q.size() == 0) begin
        $error("unexpected result steering=%0d status=%0d", out_steering_centideg, out_status);
        err_count++;
      end else begin
        exp_r = steer_q.pop_front();
        if (out_steering_centideg !== exp_r.steer) begin
          $error("steering_centideg expected %0d actual %0d", exp_r.steer,
                 out_steering_centideg);
          err_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          err_count++;
        end
      end
    end
  end

  initial begin
    restore_defaults();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_tiny_distance();
    test_zero_config();
    write_all(252, 350, 250, 40, 2500, 640, 480);
    stall_mode = 1;
    test_random_paths(200);
    test_random_configs();
    if (err_count == 0 && steer_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (steer_q.size() != 0) $error("%0d results never arrived", steer_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
